// File: src/mgm_pkg.sv
package mgm_pkg;

	localparam int CFG_ADDR_W = 5;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_SLAVE_ADDRESS = 3'd0;
	localparam logic [2:0] REG_COMMAND_BASE  = 3'd1;
	localparam logic [2:0] REG_STATUS_BASE   = 3'd2;
	localparam logic [2:0] REG_GRIP_SPEED    = 3'd3;
	localparam logic [2:0] REG_GRIP_FORCE    = 3'd4;
	localparam logic [2:0] REG_LEGACY_LAYOUT = 3'd5;

	// Operation codes of an input item.
	localparam logic [1:0] OP_RX_BYTE = 2'd0;
	localparam logic [1:0] OP_TIMEOUT = 2'd1;
	localparam logic [1:0] OP_STATUS  = 2'd2;
	localparam logic [1:0] OP_COMMAND = 2'd3;

	// Verdict codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_SHORT       = 3'd1;
	localparam logic [2:0] ST_BAD_CRC     = 3'd2;
	localparam logic [2:0] ST_EXCEPTION   = 3'd3;
	localparam logic [2:0] ST_WRONG_FUNC  = 3'd4;
	localparam logic [2:0] ST_WRONG_COUNT = 3'd5;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FC_READ_INPUT = 8'h04;
	localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
	localparam logic [7:0] READ_QTY = 8'h03;
	localparam logic [7:0] READ_BYTES = 8'h06;

	localparam logic [3:0] CMD_DATA_LEN = 4'd13;
	localparam logic [3:0] STATUS_DATA_LEN = 4'd6;
	localparam logic [3:0] CMD_REPLY_LEN = 4'd8;
	localparam logic [3:0] READ_REPLY_LEN = 4'd11;
	localparam logic [3:0] MAX_REPLY_LEN = 4'd11;

	localparam logic [7:0]  RST_SLAVE_ADDRESS = 8'd9;
	localparam logic [15:0] RST_COMMAND_BASE  = 16'd1000;
	localparam logic [15:0] RST_STATUS_BASE   = 16'd2000;
	localparam logic [7:0]  RST_GRIP_SPEED    = 8'd128;
	localparam logic [7:0]  RST_GRIP_FORCE    = 8'd128;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
		logic       activate;
		logic       go;
		logic [7:0] position;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		logic       verdict_valid;
		logic [2:0] status;
		logic       activated;
		logic [1:0] gripper_status;
		logic [1:0] object_status;
		logic [3:0] fault;
		logic [7:0] echo_position;
		logic [7:0] actual_position;
		logic [7:0] motor_current;
	} result_t;

	typedef struct packed {
		logic [7:0]  slave_address;
		logic [15:0] command_register_base;
		logic [15:0] status_register_base;
		logic [7:0]  grip_speed;
		logic [7:0]  grip_force;
		logic        legacy_layout;
	} cfg_t;

	// One byte through CRC-16/MODBUS, reflected form.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: src/mgm_regs.sv
module mgm_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mgm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output mgm_pkg::cfg_t                  cfg
);
	import mgm_pkg::*;

	cfg_t        cfg_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address         <= RST_SLAVE_ADDRESS;
			cfg_q.command_register_base <= RST_COMMAND_BASE;
			cfg_q.status_register_base  <= RST_STATUS_BASE;
			cfg_q.grip_speed            <= RST_GRIP_SPEED;
			cfg_q.grip_force            <= RST_GRIP_FORCE;
			cfg_q.legacy_layout         <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SLAVE_ADDRESS: cfg_q.slave_address <= pwdata[7:0];
				REG_COMMAND_BASE:  cfg_q.command_register_base <= pwdata[15:0];
				REG_STATUS_BASE:   cfg_q.status_register_base <= pwdata[15:0];
				REG_GRIP_SPEED:    cfg_q.grip_speed <= pwdata[7:0];
				REG_GRIP_FORCE:    cfg_q.grip_force <= pwdata[7:0];
				REG_LEGACY_LAYOUT: cfg_q.legacy_layout <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SLAVE_ADDRESS: prdata = {24'd0, cfg_q.slave_address};
			REG_COMMAND_BASE:  prdata = {16'd0, cfg_q.command_register_base};
			REG_STATUS_BASE:   prdata = {16'd0, cfg_q.status_register_base};
			REG_GRIP_SPEED:    prdata = {24'd0, cfg_q.grip_speed};
			REG_GRIP_FORCE:    prdata = {24'd0, cfg_q.grip_force};
			REG_LEGACY_LAYOUT: prdata = {31'd0, cfg_q.legacy_layout};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

// File: src/modbus_rtu_gripper_master.sv
// Modbus RTU master for a gripper. A send-command item produces a 15-byte
// write-multiple-registers request and a send-status item an 8-byte
// read-input-registers request, each ending in a CRC-16/MODBUS trailer, low
// byte first; the bytes leave one result beat per cycle while the output is
// not stalled, the CRC advancing one data byte per beat. A receive byte that
// completes a reply, or a timeout during a reply, yields one verdict beat.
// Items are handled strictly in order, and the next item is taken in the same
// cycle that the previous one finishes. Configuration sits on an APB port at
// byte address 4*i and must only be written while the block is idle.
module modbus_rtu_gripper_master (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  mgm_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output mgm_pkg::result_t               result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mgm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import mgm_pkg::*;

	cfg_t cfg;

	mgm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Item stage.
	item_t       item_s1;
	logic        valid_s1;

	// Request serializer.
	logic [3:0]  idx_q;
	logic [15:0] tx_crc_q;

	// Reply collection.
	logic [15:0] running_crc_q;
	logic [3:0]  received_count_q;
	logic [3:0]  expected_length_q;
	logic        awaiting_read_q;
	logic        reply_pending_q;
	logic [7:0]  reply_q [1:7];
	logic [7:0]  prev_rx_q;

	// Output register.
	result_t     result_q;
	logic        result_valid_q;

	logic        out_free;
	logic        frame_s1;
	logic        is_cmd;
	logic [3:0]  data_len;
	logic [15:0] crc_cur;
	logic [7:0]  frame_byte;
	logic        frame_last;
	logic        emit;
	logic        rx_s1;
	logic        rx_has_result;
	logic        rx_go;
	logic        rx_store;
	logic        rx_final;
	logic [4:0]  count_inc;
	logic [7:0]  b0;
	logic [7:0]  fc;
	logic [7:0]  want_fc;
	logic [2:0]  verdict;
	result_t     tx_res;
	result_t     rx_res;

	assign out_free     = !result_valid_q || result_ready;
	assign frame_s1     = valid_s1 && item_s1.operation[1];
	assign rx_s1        = valid_s1 && !item_s1.operation[1];
	assign is_cmd       = item_s1.operation == OP_COMMAND;
	assign data_len     = is_cmd ? CMD_DATA_LEN : STATUS_DATA_LEN;
	assign crc_cur      = (idx_q == 4'd0) ? CRC_INIT : tx_crc_q;
	assign frame_last   = idx_q == data_len + 4'd1;
	assign emit         = frame_s1 && out_free;
	assign b0           = {4'd0, item_s1.go, 2'b00, item_s1.activate};
	assign count_inc    = {1'b0, received_count_q} + 5'd1;

	// Request byte at position idx_q of the data part.
	always_comb begin
		frame_byte = 8'h00;
		case (idx_q)
			4'd0: frame_byte = cfg.slave_address;
			4'd1: frame_byte = is_cmd ? FC_WRITE_MULTI : FC_READ_INPUT;
			4'd2: frame_byte = is_cmd ? cfg.command_register_base[15:8]
			                          : cfg.status_register_base[15:8];
			4'd3: frame_byte = is_cmd ? cfg.command_register_base[7:0]
			                          : cfg.status_register_base[7:0];
			4'd4: frame_byte = 8'h00;
			4'd5: frame_byte = READ_QTY;
			4'd6: frame_byte = READ_BYTES;
			4'd7: frame_byte = b0;
			4'd8: frame_byte = cfg.legacy_layout ? item_s1.position : 8'h00;
			4'd9: frame_byte = cfg.legacy_layout ? cfg.grip_speed : 8'h00;
			4'd10: frame_byte = cfg.legacy_layout ? cfg.grip_force : item_s1.position;
			4'd11: frame_byte = cfg.legacy_layout ? 8'h00 : cfg.grip_speed;
			4'd12: frame_byte = cfg.legacy_layout ? 8'h00 : cfg.grip_force;
			default: frame_byte = 8'h00;
		endcase
	end

	always_comb begin
		tx_res = '0;
		tx_res.tx_valid = 1'b1;
		if (idx_q < data_len) begin
			tx_res.tx_byte = frame_byte;
		end else if (idx_q == data_len) begin
			tx_res.tx_byte = crc_cur[7:0];
		end else begin
			tx_res.tx_byte = crc_cur[15:8];
			tx_res.last    = 1'b1;
		end
	end

	// Reply handling for receive and timeout items.
	assign fc      = reply_q[1];
	assign want_fc = awaiting_read_q ? FC_READ_INPUT : FC_WRITE_MULTI;

	always_comb begin
		rx_store = 1'b0;
		rx_final = 1'b0;
		rx_has_result = 1'b0;
		if (reply_pending_q) begin
			if (item_s1.operation == OP_TIMEOUT) begin
				rx_has_result = 1'b1;
			end else if (received_count_q >= expected_length_q ||
			             received_count_q >= MAX_REPLY_LEN) begin
				rx_has_result = 1'b1;
			end else begin
				rx_store = 1'b1;
				if (count_inc == {1'b0, expected_length_q}) begin
					rx_final = 1'b1;
					rx_has_result = 1'b1;
				end
			end
		end
	end

	always_comb begin
		if ({item_s1.rx_byte, prev_rx_q} != running_crc_q) begin
			verdict = ST_BAD_CRC;
		end else if (fc[7]) begin
			verdict = ST_EXCEPTION;
		end else if (fc != want_fc) begin
			verdict = ST_WRONG_FUNC;
		end else if (awaiting_read_q && reply_q[2] != READ_BYTES) begin
			verdict = ST_WRONG_COUNT;
		end else begin
			verdict = ST_OK;
		end
	end

	always_comb begin
		rx_res = '0;
		rx_res.verdict_valid = 1'b1;
		rx_res.status = ST_SHORT;
		if (rx_final) begin
			rx_res.status = verdict;
			if (verdict == ST_OK && awaiting_read_q) begin
				rx_res.activated       = reply_q[3][0];
				rx_res.gripper_status  = reply_q[3][5:4];
				rx_res.object_status   = reply_q[3][7:6];
				rx_res.fault           = reply_q[4][3:0];
				rx_res.echo_position   = reply_q[5];
				rx_res.actual_position = reply_q[6];
				rx_res.motor_current   = reply_q[7];
			end
		end
	end

	// A receive item with no result finishes without waiting on the output.
	assign rx_go      = rx_s1 && (!rx_has_result || out_free);
	assign item_ready = !valid_s1 || (emit && frame_last) || rx_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 4'd0;
		end else if (emit) begin
			idx_q <= frame_last ? 4'd0 : idx_q + 4'd1;
		end
	end

	// Only the data bytes enter the CRC; the trailer beats read it unchanged.
	always_ff @(posedge clk) begin
		if (emit && idx_q < data_len) begin
			tx_crc_q <= crc_update(crc_cur, frame_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q     <= CRC_INIT;
			received_count_q  <= 4'd0;
			expected_length_q <= 4'd0;
			awaiting_read_q   <= 1'b0;
			reply_pending_q   <= 1'b0;
		end else if (emit && idx_q == 4'd0) begin
			running_crc_q     <= CRC_INIT;
			received_count_q  <= 4'd0;
			expected_length_q <= is_cmd ? CMD_REPLY_LEN : READ_REPLY_LEN;
			awaiting_read_q   <= !is_cmd;
			reply_pending_q   <= 1'b1;
		end else if (rx_go) begin
			if (rx_has_result) begin
				reply_pending_q <= 1'b0;
			end
			if (rx_store) begin
				received_count_q <= count_inc[3:0];
				// The two trailer bytes stay out of the running CRC.
				if ({1'b0, received_count_q} + 5'd2 < {1'b0, expected_length_q}) begin
					running_crc_q <= crc_update(running_crc_q, item_s1.rx_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_go && rx_store) begin
			prev_rx_q <= item_s1.rx_byte;
			for (int k = 1; k <= 7; k++) begin
				if (received_count_q == 4'(k)) begin
					reply_q[k] <= item_s1.rx_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit || (rx_go && rx_has_result)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= tx_res;
		end else if (rx_go && rx_has_result) begin
			result_q <= rx_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
